// File: sv/qph_pkg.sv
// Shared types and constants for the quadratic probe hash table.
// No dependencies; imported by the top level.
package qph_pkg;

    // register file
    localparam int REG_W   = 11;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_DIVISOR    = 1'b1;

    localparam logic [REG_W-1:0] TABLE_SIZE_RST = 11'd16;
    localparam logic [REG_W-1:0] DIVISOR_RST    = 11'd11;

    // result fields
    localparam int STATUS_W = 2;
    localparam int PROBES_W = 12;
    localparam int SLOT_W   = 11;

    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_WRAP,
        ST_READ,
        ST_CHECK
    } state_t;

endpackage

// File: sv/qph_div.sv
// Bit-serial restoring divider, one quotient bit a cycle; only the remainder is kept.
// Standalone; used by the top level for both hash reductions.
module qph_div #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [DEN_W-1:0] rem
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             run_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = DEN_W'(trial - {1'b0, den_reg});
        end
        else
        begin
            rem_next = DEN_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: sv/qph_mem.sv
// Slot memory: one valid bit and one key per entry, one write and one registered read port.
// Standalone; instantiated by the top level.
module qph_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/quadratic_probe_hash_table.sv
// Quadratic probe hash table: top level with register file and probe sequencer.
// Depends on qph_pkg, qph_div and qph_mem.
//
// One command (insert or search) is taken when start is high and busy is low; busy then
// stays high until the result beat, which is shown on status/probes/slot for exactly one
// cycle with done high and cannot be held off. A command makes two serial remainder passes
// (key mod divisor, then mod table size) in the shared divider, then examines slots, each
// in two states: ST_READ forms the address, ST_CHECK compares the registered memory read.
// After reset the block sweeps the slot memory, clearing one entry a cycle, and holds busy
// high; register writes are taken during that sweep.
module quadratic_probe_hash_table
    import qph_pkg::*;
#(
    parameter int MAX_SLOTS = 1024,
    parameter int KEY_BITS  = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic                mode,
    input  logic [KEY_BITS-1:0] key,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [PROBES_W-1:0] probes,
    output logic [SLOT_W-1:0]   slot
);

    localparam int IW    = $clog2(MAX_SLOTS);
    localparam int SW    = IW + 1;
    localparam int DEN_W = (SW > REG_W) ? SW : REG_W;
    localparam int MW    = KEY_BITS + 1;

    // register file
    logic [REG_W-1:0] table_size_reg;
    logic [REG_W-1:0] divisor_reg;
    logic             cfg_wr;

    // sequencer
    state_t               state_reg, state_next;
    logic [IW-1:0]        clr_reg, clr_next;
    logic                 mode_reg, mode_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [IW-1:0]        home_reg, home_next;
    logic [SW-1:0]        sq_reg, sq_next;
    logic [SW-1:0]        odd_reg, odd_next;
    logic                 dir_reg, dir_next;
    logic [PROBES_W-1:0]  cnt_reg, cnt_next;
    logic [IW-1:0]        tgt_reg, tgt_next;
    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [PROBES_W-1:0]  probes_reg, probes_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;

    // effective operands
    logic [SW-1:0]    size_eff;
    logic             size_one;
    logic [DEN_W-1:0] div_eff;

    // probe arithmetic
    logic [SW:0]   sq_sum;
    logic [SW:0]   odd_sum;
    logic [SW:0]   fwd_sum;
    logic [SW:0]   back_sum;
    logic [SW:0]   pos_sum;
    logic [SW-1:0] sq_step;
    logic [SW-1:0] odd_step;
    logic [IW-1:0] probe_pos;

    // divider and memory ports
    logic                div_go;
    logic [KEY_BITS-1:0] div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_done;
    logic [DEN_W-1:0]    div_rem;
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [MW-1:0]       mem_wdata;
    logic [MW-1:0]       mem_rdata;
    logic                rd_valid;
    logic                rd_hit;
    logic                cnt_at_size;
    logic                cnt_at_full;

    // ---------------------------------------------------------------- registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RST;
            divisor_reg    <= DIVISOR_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_TABLE_SIZE: table_size_reg <= pwdata[REG_W-1:0];
                REG_DIVISOR:    divisor_reg    <= pwdata[REG_W-1:0];
                default:        table_size_reg <= table_size_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TABLE_SIZE: prdata = DATA_W'(table_size_reg);
            REG_DIVISOR:    prdata = DATA_W'(divisor_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- operands
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            size_eff = SW'(1);
        end
        else if (32'(table_size_reg) > MAX_SLOTS)
        begin
            size_eff = SW'(MAX_SLOTS);
        end
        else
        begin
            size_eff = SW'(table_size_reg);
        end
        size_one = (size_eff == SW'(1));
        div_eff  = (divisor_reg == '0) ? DEN_W'(1) : DEN_W'(divisor_reg);
    end

    // i*i mod size advances by the running odd number 2i+1 mod size
    always_comb
    begin
        sq_sum  = (SW+1)'(sq_reg) + (SW+1)'(odd_reg);
        sq_step = (sq_sum >= (SW+1)'(size_eff)) ? SW'(sq_sum - (SW+1)'(size_eff))
                                                : SW'(sq_sum);
        odd_sum = (SW+1)'(odd_reg) + (SW+1)'(2);
        if (size_one)
        begin
            odd_step = '0;
        end
        else if (odd_sum >= (SW+1)'(size_eff))
        begin
            odd_step = SW'(odd_sum - (SW+1)'(size_eff));
        end
        else
        begin
            odd_step = SW'(odd_sum);
        end
        fwd_sum   = (SW+1)'(home_reg) + (SW+1)'(sq_reg);
        back_sum  = (SW+1)'(home_reg) + (SW+1)'(size_eff) - (SW+1)'(sq_reg);
        pos_sum   = dir_reg ? back_sum : fwd_sum;
        probe_pos = (pos_sum >= (SW+1)'(size_eff)) ? IW'(pos_sum - (SW+1)'(size_eff))
                                                   : IW'(pos_sum);
    end

    assign rd_valid    = mem_rdata[MW-1];
    assign rd_hit      = rd_valid && (mem_rdata[KEY_BITS-1:0] == key_reg);
    assign cnt_at_size = (32'(cnt_reg) == 32'(size_eff));
    assign cnt_at_full = (32'(cnt_reg) == 2 * 32'(size_eff));

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        home_reg   <= home_next;
        sq_reg     <= sq_next;
        odd_reg    <= odd_next;
        dir_reg    <= dir_next;
        cnt_reg    <= cnt_next;
        tgt_reg    <= tgt_next;
        status_reg <= status_next;
        probes_reg <= probes_next;
        slot_reg   <= slot_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        home_next   = home_reg;
        sq_next     = sq_reg;
        odd_next    = odd_reg;
        dir_next    = dir_reg;
        cnt_next    = cnt_reg;
        tgt_next    = tgt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        probes_next = probes_reg;
        slot_next   = slot_reg;
        div_go      = 1'b0;
        div_num     = key;
        div_den     = div_eff;
        mem_we      = 1'b0;
        mem_waddr   = tgt_reg;
        mem_wdata   = {1'b1, key_reg};

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (32'(clr_reg) == MAX_SLOTS - 1)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    key_next   = key;
                    div_go     = 1'b1;
                    state_next = ST_HASH;
                end
            end

            ST_HASH:
            begin
                // second pass folds the hash into the table
                div_num = KEY_BITS'(div_rem);
                div_den = DEN_W'(size_eff);
                if (div_done)
                begin
                    div_go     = 1'b1;
                    state_next = ST_WRAP;
                end
            end

            ST_WRAP:
            begin
                if (div_done)
                begin
                    home_next  = IW'(div_rem);
                    sq_next    = '0;
                    odd_next   = size_one ? SW'(0) : SW'(1);
                    dir_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                tgt_next   = probe_pos;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                state_next = ST_READ;
                if (mode_reg == MODE_INSERT)
                begin
                    if (!rd_valid)
                    begin
                        mem_we      = 1'b1;
                        done_next   = 1'b1;
                        status_next = STAT_INSERTED;
                        probes_next = cnt_reg;
                        slot_next   = SLOT_W'(32'(tgt_reg) + 1);
                        state_next  = ST_IDLE;
                    end
                    else if (cnt_at_full)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_FULL;
                        probes_next = cnt_reg;
                        slot_next   = '0;
                        state_next  = ST_IDLE;
                    end
                    else if (!dir_reg)
                    begin
                        dir_next = 1'b1;
                    end
                    else
                    begin
                        dir_next = 1'b0;
                        sq_next  = sq_step;
                        odd_next = odd_step;
                    end
                end
                else
                begin
                    if (rd_hit)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_FOUND;
                        probes_next = cnt_reg;
                        slot_next   = SLOT_W'(32'(tgt_reg) + 1);
                        state_next  = ST_IDLE;
                    end
                    else if (!rd_valid ||
                             ((cnt_reg != PROBES_W'(1)) &&
                              ((tgt_reg == home_reg) || cnt_at_size)))
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_NOT_FOUND;
                        probes_next = cnt_reg;
                        slot_next   = '0;
                        state_next  = ST_IDLE;
                    end
                    else if (cnt_reg == PROBES_W'(1) || dir_reg)
                    begin
                        // home probe alone makes round zero; then advance the round
                        dir_next = 1'b0;
                        sq_next  = sq_step;
                        odd_next = odd_step;
                    end
                    else
                    begin
                        dir_next = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- units
    qph_div #(
        .NUM_W (KEY_BITS),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .rem   (div_rem)
    );

    qph_mem #(
        .DEPTH  (MAX_SLOTS),
        .DATA_W (MW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (probe_pos),
        .rdata (mem_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign probes = probes_reg;
    assign slot   = slot_reg;

endmodule
